/* hdl/sine_weighted_moving_average_assert.svh */
// Assertion macros for the sine weighted moving average block.
// Used by the controller; expects clk and rst_n in the including scope.
`ifndef SINE_WEIGHTED_MOVING_AVERAGE_ASSERT_SVH
`define SINE_WEIGHTED_MOVING_AVERAGE_ASSERT_SVH
`ifndef SYNTHESIS
`define SWMA_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("%m: assertion failed");
`define SWMA_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: assertion failed");
`define SWMA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: assertion failed");
`else
`define SWMA_ASSERT(lbl, prop)
`define SWMA_ASSERT_IMPL(lbl, ante, cons)
`define SWMA_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* hdl/swma_pkg.sv */
// Shared types, constants and the sine weight table for the moving average.
// No dependencies.
package swma_pkg;

    localparam int MAX_PERIOD    = 64;
    localparam int PERIOD_W      = 7;
    localparam int SLOT_W        = $clog2(MAX_PERIOD);
    localparam int SAMPLE_W      = 32;
    localparam int WEIGHT_W      = 17;
    localparam int WIDX_W        = 4;
    localparam int WEIGHT_PERIOD = 12;
    localparam int PROD_W        = SAMPLE_W + WEIGHT_W;
    localparam int ACC_W         = 56;
    localparam int WSUM_W        = 18;
    localparam int DIV_STEPS     = ACC_W;
    localparam int DCNT_W        = $clog2(DIV_STEPS);

    localparam logic [ACC_W-1:0] MAG_POS_LIM = ACC_W'(64'h0000_0000_7FFF_FFFF);
    localparam logic [ACC_W-1:0] MAG_NEG_LIM = ACC_W'(64'h0000_0000_8000_0000);
    localparam logic [SAMPLE_W-1:0] AVG_MAX  = 32'h7FFF_FFFF;
    localparam logic [SAMPLE_W-1:0] AVG_MIN  = 32'h8000_0000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAC,
        ST_CHECK,
        ST_DIV,
        ST_LOAD
    } state_t;

    typedef struct packed {
        logic sample_take;
        logic cfg_take;
        logic tap_issue;
        logic div_start;
        logic div_step;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic                fires;
        logic [PERIOD_W-1:0] eff_period;
        logic                pipe_busy;
        logic                bad;
        logic                out_free;
    } stat_t;

    // sin((j+1)*pi/6) in Q2.15, indexed by j mod 12
    function automatic logic signed [WEIGHT_W-1:0] sine_weight(input logic [WIDX_W-1:0] idx);
        logic signed [WEIGHT_W-1:0] w;
        case (idx)
            4'd0:    w = 17'sd16384;
            4'd1:    w = 17'sd28378;
            4'd2:    w = 17'sd32768;
            4'd3:    w = 17'sd28378;
            4'd4:    w = 17'sd16384;
            4'd6:    w = -17'sd16384;
            4'd7:    w = -17'sd28378;
            4'd8:    w = -17'sd32768;
            4'd9:    w = -17'sd28378;
            4'd10:   w = -17'sd16384;
            default: w = '0;
        endcase
        return w;
    endfunction

endpackage

/* hdl/swma_ifs.sv */
// Valid/ready channel interfaces: sample input, configuration write, result.
// Depends on swma_pkg.
interface swma_in_if;
    import swma_pkg::*;
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;
    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface swma_cfg_if;
    import swma_pkg::*;
    logic                valid;
    logic                ready;
    logic [PERIOD_W-1:0] period;
    modport source (output valid, output period, input ready);
    modport sink   (input valid, input period, output ready);
endinterface

interface swma_out_if;
    import swma_pkg::*;
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] average;
    logic                       status;
    modport source (output valid, output average, output status, input ready);
    modport sink   (input valid, input average, input status, output ready);
endinterface

/* hdl/sine_weighted_moving_average.sv */
// Top level of the sine weighted moving average: controller plus datapath.
// Depends on swma_pkg, swma_ifs, swma_ctrl, swma_datapath.
//
//  channel   dir  payload                     word accepted when
//  samples   in   sample[31:0] Q16.16         samples.valid && samples.ready
//  cfg       in   period[6:0]                 cfg.valid && cfg.ready
//  results   out  average[31:0], status       results.valid && results.ready
//
// Full word: once it is taken the block runs P taps (P = effective period) through ring
// RAM and MAC, drains the MAC pipeline, checks, runs 56 divide steps and loads the result;
// the next word can go in the cycle after the load. An invalid period skips the divider.
// Warm-up words are taken without leaving idle; a period write is taken only when idle and
// wins over a sample offered in the same cycle. rst_n clears control state only.
// A waiting result stalls the block in its load state only once the next one is done.
module sine_weighted_moving_average (
    input  logic       clk,
    input  logic       rst_n,
    swma_in_if.sink    samples,
    swma_cfg_if.sink   cfg,
    swma_out_if.source results
);
    import swma_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    swma_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (samples.valid),
        .sample_ready (samples.ready),
        .cfg_valid    (cfg.valid),
        .cfg_ready    (cfg.ready),
        .cmd          (cmd),
        .stat         (stat)
    );

    swma_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .sample       (samples.sample),
        .period_wdata (cfg.period),
        .out_valid    (results.valid),
        .out_ready    (results.ready),
        .average      (results.average),
        .status       (results.status)
    );
endmodule

/* hdl/swma_ram.sv */
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module swma_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

/* hdl/swma_datapath.sv */
// Datapath: sample ring, weight MAC pipeline, serial divider, result register.
// Depends on swma_pkg and swma_ram.
module swma_datapath (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  swma_pkg::cmd_t                       cmd,
    output swma_pkg::stat_t                      stat,
    input  logic signed [swma_pkg::SAMPLE_W-1:0] sample,
    input  logic [swma_pkg::PERIOD_W-1:0]        period_wdata,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [swma_pkg::SAMPLE_W-1:0] average,
    output logic                                 status
);
    import swma_pkg::*;

    logic [PERIOD_W-1:0]        period_reg;
    logic [PERIOD_W-1:0]        eff_period;
    logic [SLOT_W-1:0]          slot_reg;
    logic [PERIOD_W-1:0]        fill_reg;
    logic [SLOT_W-1:0]          rd_ptr_reg;
    logic [WIDX_W-1:0]          widx_reg;
    logic signed [WEIGHT_W-1:0] w1_reg;
    logic signed [WEIGHT_W-1:0] w2_reg;
    logic                       v1_reg;
    logic                       v2_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [PROD_W-1:0]   prod;
    logic signed [ACC_W-1:0]    acc_reg;
    logic signed [WSUM_W-1:0]   wsum_reg;
    logic [SAMPLE_W-1:0]        ram_rdata;
    logic                       neg_reg;
    logic [ACC_W-1:0]           quo_reg;
    logic [WSUM_W-1:0]          rem_reg;
    logic [WSUM_W:0]            rem_shift;
    logic [WSUM_W:0]            rem_diff;
    logic [SAMPLE_W-1:0]        avg_sat;
    logic                       residue_bad;
    logic                       out_valid_reg;
    logic signed [SAMPLE_W-1:0] avg_reg;
    logic                       status_reg;

    always_comb
    begin
        if (period_reg == '0)
        begin
            eff_period = PERIOD_W'(1);
        end
        else if (period_reg > PERIOD_W'(MAX_PERIOD))
        begin
            eff_period = PERIOD_W'(MAX_PERIOD);
        end
        else
        begin
            eff_period = period_reg;
        end
    end

    // after the pass widx_reg holds period mod 12
    assign residue_bad = (widx_reg == 4'd0) || (widx_reg == 4'd5) ||
                         (widx_reg == 4'd6) || (widx_reg == 4'd11);

    assign stat.fires      = (fill_reg + PERIOD_W'(1)) >= eff_period;
    assign stat.eff_period = eff_period;
    assign stat.pipe_busy  = v1_reg || v2_reg;
    assign stat.bad        = (period_reg == '0) || (period_reg > PERIOD_W'(MAX_PERIOD)) ||
                             residue_bad || (wsum_reg <= 0);
    assign stat.out_free   = !out_valid_reg || out_ready;

    swma_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (MAX_PERIOD)
    ) u_ring (
        .clk   (clk),
        .we    (cmd.sample_take),
        .waddr (slot_reg),
        .wdata (sample),
        .re    (cmd.tap_issue),
        .raddr (rd_ptr_reg),
        .rdata (ram_rdata)
    );

    // control state: period, ring position, fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= PERIOD_W'(1);
            slot_reg   <= '0;
            fill_reg   <= '0;
            v1_reg     <= 1'b0;
            v2_reg     <= 1'b0;
        end
        else
        begin
            v1_reg <= cmd.tap_issue;
            v2_reg <= v1_reg;
            if (cmd.cfg_take)
            begin
                period_reg <= period_wdata;
                slot_reg   <= '0;
                fill_reg   <= '0;
            end
            else if (cmd.sample_take)
            begin
                slot_reg <= slot_reg + SLOT_W'(1);
                if (fill_reg < eff_period)
                begin
                    fill_reg <= fill_reg + PERIOD_W'(1);
                end
            end
        end
    end

    assign prod = w1_reg * $signed(ram_rdata);

    // MAC pipeline: issue, multiply, accumulate
    always_ff @(posedge clk)
    begin
        if (cmd.sample_take)
        begin
            rd_ptr_reg <= slot_reg;
            widx_reg   <= '0;
            acc_reg    <= '0;
            wsum_reg   <= '0;
        end
        else
        begin
            if (cmd.tap_issue)
            begin
                w1_reg     <= sine_weight(widx_reg);
                rd_ptr_reg <= rd_ptr_reg - SLOT_W'(1);
                widx_reg   <= (widx_reg == WIDX_W'(WEIGHT_PERIOD - 1)) ? '0
                                                                     : widx_reg + WIDX_W'(1);
            end
            if (v1_reg)
            begin
                prod_reg <= prod;
                w2_reg   <= w1_reg;
            end
            if (v2_reg)
            begin
                acc_reg  <= acc_reg + ACC_W'(prod_reg);
                wsum_reg <= wsum_reg + WSUM_W'(w2_reg);
            end
        end
    end

    // restoring division of |acc| by the weight sum, one bit per step
    assign rem_shift = {rem_reg, quo_reg[ACC_W-1]};
    assign rem_diff  = rem_shift - {1'b0, wsum_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            neg_reg <= acc_reg[ACC_W-1];
            quo_reg <= acc_reg[ACC_W-1] ? ACC_W'(-acc_reg) : ACC_W'(acc_reg);
            rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            if (!rem_diff[WSUM_W])
            begin
                rem_reg <= rem_diff[WSUM_W-1:0];
                quo_reg <= {quo_reg[ACC_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_shift[WSUM_W-1:0];
                quo_reg <= {quo_reg[ACC_W-2:0], 1'b0};
            end
        end
    end

    always_comb
    begin
        if (neg_reg)
        begin
            avg_sat = (quo_reg > MAG_NEG_LIM) ? AVG_MIN : -quo_reg[SAMPLE_W-1:0];
        end
        else
        begin
            avg_sat = (quo_reg > MAG_POS_LIM) ? AVG_MAX : quo_reg[SAMPLE_W-1:0];
        end
    end

    // result word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            avg_reg    <= stat.bad ? '0 : $signed(avg_sat);
            status_reg <= stat.bad;
        end
    end

    assign out_valid = out_valid_reg;
    assign average   = avg_reg;
    assign status    = status_reg;
endmodule

/* hdl/swma_ctrl.sv */
// Controller FSM: sequences accept, MAC pass, drain, divide and result load.
// Depends on swma_pkg and sine_weighted_moving_average_assert.svh.
`include "sine_weighted_moving_average_assert.svh"
module swma_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            sample_valid,
    output logic            sample_ready,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    output swma_pkg::cmd_t  cmd,
    input  swma_pkg::stat_t stat
);
    import swma_pkg::*;

    localparam logic [DCNT_W-1:0] DIV_LAST = DCNT_W'(DIV_STEPS - 1);

    state_t              state_reg;
    state_t              state_next;
    logic [PERIOD_W-1:0] tap_cnt_reg;
    logic [PERIOD_W-1:0] tap_cnt_next;
    logic [DCNT_W-1:0]   div_cnt_reg;
    logic [DCNT_W-1:0]   div_cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            tap_cnt_reg <= '0;
            div_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            tap_cnt_reg <= tap_cnt_next;
            div_cnt_reg <= div_cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (sample_valid && !cfg_valid && stat.fires)
                begin
                    state_next = ST_MAC;
                end
            end
            ST_MAC:
            begin
                if (tap_cnt_reg == stat.eff_period && !stat.pipe_busy)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                state_next = stat.bad ? ST_LOAD : ST_DIV;
            end
            ST_DIV:
            begin
                if (div_cnt_reg == DIV_LAST)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd          = '0;
        sample_ready = 1'b0;
        cfg_ready    = 1'b0;
        tap_cnt_next = tap_cnt_reg;
        div_cnt_next = div_cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                // a period write wins over a sample offered in the same cycle
                sample_ready    = !cfg_valid;
                cfg_ready       = 1'b1;
                cmd.sample_take = sample_valid && !cfg_valid;
                cmd.cfg_take    = cfg_valid;
                tap_cnt_next    = '0;
            end
            ST_MAC:
            begin
                cmd.tap_issue = tap_cnt_reg != stat.eff_period;
                if (cmd.tap_issue)
                begin
                    tap_cnt_next = tap_cnt_reg + PERIOD_W'(1);
                end
            end
            ST_CHECK:
            begin
                cmd.div_start = !stat.bad;
                div_cnt_next  = '0;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                div_cnt_next = div_cnt_reg + DCNT_W'(1);
            end
            ST_LOAD:
            begin
                cmd.out_load = stat.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    `SWMA_ASSERT(a_tap_bound, tap_cnt_reg <= stat.eff_period)
    `SWMA_ASSERT_IMPL(a_div_drained, state_reg == ST_DIV, !stat.pipe_busy)
    `SWMA_ASSERT_NEXT(a_warmup_idle, cmd.sample_take && !stat.fires, state_reg == ST_IDLE)
    `SWMA_ASSERT_NEXT(a_div_length, state_reg == ST_DIV && div_cnt_reg == DIV_LAST,
                      state_reg == ST_LOAD)
endmodule

/* tb/swma_checker.sv */
// Scoreboard for the sine weighted moving average: watches the sample, period and
// result channels, predicts each average and compares it with what comes out.
// Depends on swma_pkg and swma_ifs.
module swma_checker (
    input  logic clk,
    input  logic rst_n,
    swma_in_if   samples,
    swma_cfg_if  cfg,
    swma_out_if  results,
    output int   fail_count,
    output int   pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import swma_pkg::*;

    typedef struct {
        logic signed [SAMPLE_W-1:0] average;
        logic                       status;
    } avg_word_t;

    // sin((j+1)*pi/6) scaled by 2^15
    localparam logic signed [WEIGHT_W-1:0] SINE_Q15 [WEIGHT_PERIOD] = '{
        17'sd16384, 17'sd28378, 17'sd32768, 17'sd28378, 17'sd16384, 17'sd0,
        -17'sd16384, -17'sd28378, -17'sd32768, -17'sd28378, -17'sd16384, 17'sd0
    };
    localparam longint AVG_HI = 64'sd2147483647;
    localparam longint AVG_LO = -64'sd2147483648;

    logic signed [SAMPLE_W-1:0] window_ring [MAX_PERIOD];
    int unsigned                wr_slot;
    int unsigned                held;
    longint                     weight_total;
    logic [PERIOD_W-1:0]        period_reg;
    avg_word_t                  expected_avgs [$];
    int                         errs;

    function automatic int unsigned taps_of(input logic [PERIOD_W-1:0] r);
        if (r == 0)
            return 1;
        if (r > MAX_PERIOD)
            return MAX_PERIOD;
        return int'(r);
    endfunction

    function automatic bit period_rejected(input logic [PERIOD_W-1:0] r);
        int unsigned p;
        p = taps_of(r);
        if (r == 0 || r > MAX_PERIOD)
            return 1'b1;
        return (p % 6 == 0) || ((p + 1) % 6 == 0);
    endfunction

    // a period write restarts warm-up; old samples are never read again
    task automatic reload_period(input logic [PERIOD_W-1:0] r);
        int unsigned p;
        p = taps_of(r);
        period_reg   = r;
        weight_total = 0;
        for (int unsigned j = 0; j < p; j++)
            weight_total += longint'(SINE_Q15[j % WEIGHT_PERIOD]);
        wr_slot = 0;
        held    = 0;
    endtask

    task automatic absorb_sample(input logic signed [SAMPLE_W-1:0] s);
        int unsigned p;
        int unsigned slot;
        longint      acc;
        longint      q;
        avg_word_t   w;
        p = taps_of(period_reg);
        window_ring[wr_slot] = s;
        wr_slot = (wr_slot + 1) % MAX_PERIOD;
        if (held < p)
            held++;
        if (held >= p)
        begin
            w.average = '0;
            w.status  = 1'b1;
            if (!period_rejected(period_reg) && weight_total > 0)
            begin
                acc  = 0;
                slot = wr_slot;
                for (int unsigned j = 0; j < p; j++)
                begin
                    slot = (slot == 0) ? MAX_PERIOD - 1 : slot - 1;
                    acc += longint'(SINE_Q15[j % WEIGHT_PERIOD]) * longint'(window_ring[slot]);
                end
                q = acc / weight_total;   // truncates toward zero
                if (q > AVG_HI)
                    q = AVG_HI;
                if (q < AVG_LO)
                    q = AVG_LO;
                w.average = q[SAMPLE_W-1:0];
                w.status  = 1'b0;
            end
            expected_avgs.push_back(w);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        avg_word_t want;
        if (!rst_n)
        begin
            reload_period(PERIOD_W'(1));
            expected_avgs.delete();
            errs = 0;
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            // pop before push: a word taken at this edge cannot leave at the same edge
            if (results.valid && results.ready)
            begin
                if (expected_avgs.size() == 0)
                begin
                    errs++;
                    $display("%0t: result with nothing expected: average %h status %0d",
                             $time, results.average, results.status);
                end
                else
                begin
                    want = expected_avgs.pop_front();
                    if (results.average !== want.average)
                    begin
                        errs++;
                        $display("%0t: average expected %h (%0d) actual %h (%0d)", $time,
                                 want.average, want.average, results.average, results.average);
                    end
                    if (results.status !== want.status)
                    begin
                        errs++;
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, results.status);
                    end
                end
            end
            if (cfg.valid && cfg.ready)
                reload_period(cfg.period);
            if (samples.valid && samples.ready)
                absorb_sample(samples.sample);
            fail_count <= errs;
            pending    <= expected_avgs.size();
        end
    end

endmodule

/* tb/tb.sv */
// Top of the moving average testbench: clock, reset, sample and period stimulus,
// result backpressure and the verdict. Depends on swma_pkg, swma_ifs, swma_checker.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import swma_pkg::*;

    localparam int CLK_HALF     = 10;
    localparam int RUN_LIMIT    = 1_000_000;
    localparam int DRAIN_CYCLES = 200;
    localparam int STALL_CYCLES = 1500;
    localparam int RANDOM_WORDS = 900;
    localparam logic signed [SAMPLE_W-1:0] S_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [SAMPLE_W-1:0] S_MIN = 32'sh8000_0000;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    bit   steady;
    bit   squeeze;
    int   cycles;
    int   sent;

    swma_in_if  samples_ch ();
    swma_cfg_if cfg_ch ();
    swma_out_if results_ch ();

    sine_weighted_moving_average DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples_ch),
        .cfg     (cfg_ch),
        .results (results_ch)
    );

    swma_checker avg_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .samples    (samples_ch),
        .cfg        (cfg_ch),
        .results    (results_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial clk = 1'b0;
    always #CLK_HALF clk = ~clk;

    function automatic int gap_len();
        int n;
        n = 0;
        if (!steady)
            while ($urandom_range(99) < 23)
                n++;
        return n;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(3))
            0, 1: return $urandom;
            2:    return $urandom_range(0, 32'h0FFF_FFFF);   // price-like values
            default:
            begin
                case ($urandom_range(3))
                    0:       return S_MAX;
                    1:       return S_MIN;
                    2:       return '0;
                    default: return -1;
                endcase
            end
        endcase
    endfunction

    function automatic logic [PERIOD_W-1:0] pick_period();
        case ($urandom_range(15))
            0:       return '0;
            1:       return PERIOD_W'(MAX_PERIOD);
            2:       return PERIOD_W'($urandom_range(MAX_PERIOD + 1, 127));
            3:       return PERIOD_W'(6 * $urandom_range(1, 10));
            4:       return PERIOD_W'(6 * $urandom_range(1, 10) - 1);
            5:       return PERIOD_W'($urandom_range(17, MAX_PERIOD - 1));
            default: return PERIOD_W'($urandom_range(1, 16));
        endcase
    endfunction

    task automatic send_sample(input logic signed [SAMPLE_W-1:0] s);
        int n;
        n = gap_len();
        if (n > 0)
        begin
            samples_ch.valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
        samples_ch.valid  <= 1'b1;
        samples_ch.sample <= s;
        do @(posedge clk); while (!samples_ch.ready);
    endtask

    task automatic write_period(input logic [PERIOD_W-1:0] p);
        cfg_ch.valid  <= 1'b1;
        cfg_ch.period <= p;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
    endtask

    // warm-up words give no result, so a quiet pause follows the last one
    task automatic settle();
        samples_ch.valid <= 1'b0;
        do
        begin
            while (pending != 0)
                @(posedge clk);
            repeat (DRAIN_CYCLES) @(posedge clk);
        end
        while (pending != 0);
    endtask

    task automatic run_phase(input logic [PERIOD_W-1:0] p, input int extra);
        int taps;
        taps = (p == 0) ? 1 : ((p > MAX_PERIOD) ? MAX_PERIOD : int'(p));
        write_period(p);
        repeat (taps + extra)
            send_sample(pick_sample());
        sent += taps + extra;
        settle();
    endtask

    // result side: random stalls, one long hold-off while the sender keeps pushing
    initial
    begin
        int hold_left;
        bit held_done;
        hold_left = 0;
        held_done = 1'b0;
        results_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (squeeze && !held_done)
            begin
                hold_left = STALL_CYCLES;
                held_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                results_ch.ready <= 1'b0;
                hold_left--;
            end
            else
                results_ch.ready <= steady || ($urandom_range(99) >= 23);
        end
    end

    initial
    begin
        cycles = 0;
        while (cycles < RUN_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        samples_ch.valid  = 1'b0;
        samples_ch.sample = '0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.period     = PERIOD_W'(1);
        steady            = 1'b0;
        squeeze           = 1'b0;
        sent              = 0;
        rst_n             = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // period 1 out of reset: each word comes back unchanged
        send_sample(S_MAX);
        send_sample(S_MIN);
        send_sample('0);
        send_sample(-1);
        settle();

        // period 8 has negative taps: drive both saturation limits
        write_period(PERIOD_W'(8));
        repeat (2) send_sample(S_MIN);
        send_sample('0);
        repeat (5) send_sample(S_MAX);
        repeat (2) send_sample(S_MAX);
        send_sample('0);
        repeat (5) send_sample(S_MIN);
        settle();

        // zero register: clamped window of one, status invalid
        write_period('0);
        send_sample(32'sh1234_5678);
        send_sample(S_MIN);
        settle();

        // one less than a multiple of six: invalid after warm-up
        write_period(PERIOD_W'(5));
        repeat (5) send_sample(pick_sample());
        settle();

        run_phase(PERIOD_W'(127), 6);
        run_phase(PERIOD_W'(MAX_PERIOD), 6);

        steady <= 1'b1;
        run_phase(PERIOD_W'(1), 60);
        steady <= 1'b0;

        squeeze <= 1'b1;
        run_phase(PERIOD_W'(3), 40);
        squeeze <= 1'b0;

        while (sent < RANDOM_WORDS)
            run_phase(pick_period(), $urandom_range(4, 30));

        if (fail_count == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
